FILE: rtl/lfp_pkg.sv
package lfp_pkg;

  // widths and sizes
  localparam int INTEGRAL_BITS = 24;
  localparam int PWM_TOP       = 99;
  localparam int BYTE_W        = 8;
  localparam int GAIN_W        = 10;
  localparam int CFG_IDX_W     = 3;
  localparam int CNT_W         = 7;
  localparam int DUTY_W        = 7;
  localparam int ERR_W         = 10;
  localparam int DERR_W        = 11;
  localparam int RVAL_W        = 9;
  localparam int PROD_PD_W     = 21;
  localparam int PROD_I_W      = INTEGRAL_BITS + GAIN_W + 1;
  localparam int TOTAL_W       = INTEGRAL_BITS + GAIN_W + 2;
  localparam int MAG_W         = 22;
  localparam int RECIP_W       = 23;
  localparam int PRODQ_W       = MAG_W + RECIP_W;
  localparam int Q_W           = 16;
  localparam int TURN_W        = 16;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 32;

  // right sensor scaling by 9/10: x * 58986 >> 16 is exact for 8-bit x
  localparam logic [15:0] SCALE9_10  = 16'd58986;
  localparam int          SCALE_SHIFT = 16;

  // division by 100: x * 5368710 >> 29 is exact for x below 2^22
  localparam logic [RECIP_W-1:0] DIV_RECIP = 23'd5368710;
  localparam int                 DIV_SHIFT = 29;
  // magnitude at which the quotient reaches 32768
  localparam int                 MAG_CLAMP = 3276800;

  localparam logic [DUTY_W-1:0] DUTY_FULL  = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd90;
  localparam logic [Q_W-1:0]    TURN_POS_MAX = 16'd32767;

  // wheel direction codes
  localparam logic [1:0] STATUS_FWD = 2'd1;
  localparam logic [1:0] STATUS_BWD = 2'd2;

  // junction event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_FIRST = 2'd1;
  localparam logic [1:0] EV_LATER = 2'd2;
  localparam logic [1:0] JUNCTIONS_MAX = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_TH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JUNC_PER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_OFS  = 3'd5;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [BYTE_W-1:0] dark_threshold;
    logic [BYTE_W-1:0] junction_periods;
    logic [BYTE_W-1:0] right_offset;
  } cfg_t;

  // per-stage tag that follows every tick down the pipeline
  typedef struct packed {
    logic             valid;
    logic             is_end;
    logic [CNT_W-1:0] count;
  } tag_t;

endpackage

FILE: rtl/lfp_error.sv
module lfp_error (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  lfp_pkg::cfg_t                            cfg,
  input  lfp_pkg::tag_t                            tag1,
  input  lfp_pkg::tag_t                            tag2,
  input  logic [lfp_pkg::BYTE_W-1:0]               left1,
  input  logic [lfp_pkg::BYTE_W-1:0]               right1,
  output logic signed [lfp_pkg::ERR_W-1:0]         err3,
  output logic signed [lfp_pkg::INTEGRAL_BITS-1:0] esum3,
  output logic signed [lfp_pkg::DERR_W-1:0]        derr3,
  output logic [1:0]                               event3
);

  localparam int IB = lfp_pkg::INTEGRAL_BITS;

  logic [23:0]                        scale_prod;
  logic [lfp_pkg::RVAL_W-1:0]         right_val;
  logic signed [lfp_pkg::ERR_W-1:0]   err_a;
  logic                               dark_a;

  logic signed [lfp_pkg::ERR_W-1:0]   err2;
  logic                               dark2;

  logic signed [IB-1:0]               error_sum;
  logic signed [lfp_pkg::ERR_W-1:0]   prev_error;
  logic [lfp_pkg::BYTE_W-1:0]         dark_count;
  logic [1:0]                         junctions_seen;

  logic signed [IB:0]                 sum_b;
  logic signed [IB-1:0]               esum_sat;
  logic signed [lfp_pkg::DERR_W-1:0]  derr_b;
  logic [lfp_pkg::BYTE_W-1:0]         dc_inc;
  logic [lfp_pkg::BYTE_W-1:0]         dark_count_next;
  logic [1:0]                         junctions_seen_next;
  logic                               junction;
  logic [1:0]                         event_b;

  // scaled right reading, error and dark test
  always_comb begin
    scale_prod = 24'(right1) * 24'(lfp_pkg::SCALE9_10);
    right_val  = lfp_pkg::RVAL_W'(scale_prod[lfp_pkg::SCALE_SHIFT +: lfp_pkg::BYTE_W])
               + lfp_pkg::RVAL_W'(cfg.right_offset);
    err_a      = lfp_pkg::ERR_W'(left1) - lfp_pkg::ERR_W'(right_val);
    dark_a     = (left1 >= cfg.dark_threshold) &&
                 (right_val >= lfp_pkg::RVAL_W'(cfg.dark_threshold));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err2  <= err_a;
      dark2 <= dark_a;
    end
  end

  // saturating integral, derivative and junction detection
  always_comb begin
    sum_b = (IB+1)'(error_sum) + (IB+1)'(err2);
    if (sum_b[IB] != sum_b[IB-1]) begin
      esum_sat = sum_b[IB] ? {1'b1, {(IB-1){1'b0}}} : {1'b0, {(IB-1){1'b1}}};
    end else begin
      esum_sat = sum_b[IB-1:0];
    end
    derr_b = lfp_pkg::DERR_W'(err2) - lfp_pkg::DERR_W'(prev_error);

    dc_inc              = (dark_count == '1) ? dark_count : dark_count + 1'b1;
    dark_count_next     = '0;
    junctions_seen_next = junctions_seen;
    junction            = 1'b0;
    event_b             = lfp_pkg::EV_NONE;
    if (dark2) begin
      if (dc_inc > cfg.junction_periods) begin
        junction = 1'b1;
        if (junctions_seen < lfp_pkg::JUNCTIONS_MAX) begin
          junctions_seen_next = junctions_seen + 1'b1;
        end
        event_b = (junctions_seen_next == lfp_pkg::EV_FIRST) ? lfp_pkg::EV_FIRST
                                                             : lfp_pkg::EV_LATER;
      end else begin
        dark_count_next = dc_inc;
      end
    end
  end

  // controller memory, updated by the period-end tick
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      prev_error     <= '0;
      dark_count     <= '0;
      junctions_seen <= '0;
    end else if (en && tag2.valid && tag2.is_end) begin
      error_sum      <= junction ? '0 : esum_sat;
      prev_error     <= junction ? '0 : err2;
      dark_count     <= dark_count_next;
      junctions_seen <= junctions_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err3   <= err2;
      esum3  <= esum_sat;
      derr3  <= derr_b;
      event3 <= (tag2.is_end && tag1.valid | !tag1.valid) && tag2.is_end ? event_b
                                                                         : lfp_pkg::EV_NONE;
    end
  end

endmodule

FILE: rtl/lfp_pid.sv
module lfp_pid (
  input  logic                                     clk,
  input  logic                                     en,
  input  lfp_pkg::cfg_t                            cfg,
  input  logic signed [lfp_pkg::ERR_W-1:0]         err3,
  input  logic signed [lfp_pkg::INTEGRAL_BITS-1:0] esum3,
  input  logic signed [lfp_pkg::DERR_W-1:0]        derr3,
  output logic [lfp_pkg::Q_W-1:0]                  q_mag,
  output logic                                     q_neg
);

  localparam int TW = lfp_pkg::TOTAL_W;

  logic signed [lfp_pkg::PROD_PD_W-1:0] prod_p;
  logic signed [lfp_pkg::PROD_I_W-1:0]  prod_i;
  logic signed [lfp_pkg::PROD_PD_W-1:0] prod_d;
  logic signed [TW-1:0]                 total;
  logic                                 neg6;
  logic [TW-1:0]                        mag_full;
  logic [lfp_pkg::MAG_W-1:0]            mag6;
  logic [lfp_pkg::PRODQ_W-1:0]          prodq;

  // three gain products
  always_ff @(posedge clk) begin
    if (en) begin
      prod_p <= lfp_pkg::PROD_PD_W'($signed({1'b0, cfg.gain_p}) * err3);
      prod_i <= lfp_pkg::PROD_I_W'($signed({1'b0, cfg.gain_i}) * esum3);
      prod_d <= lfp_pkg::PROD_PD_W'($signed({1'b0, cfg.gain_d}) * derr3);
    end
  end

  // controller sum
  always_ff @(posedge clk) begin
    if (en) begin
      total <= TW'(prod_p) + TW'(prod_i) + TW'(prod_d);
    end
  end

  // magnitude, clamped where the quotient saturates anyway
  assign mag_full = total[TW-1] ? TW'(-total) : TW'(total);

  always_ff @(posedge clk) begin
    if (en) begin
      neg6 <= total[TW-1];
      mag6 <= (mag_full >= TW'(lfp_pkg::MAG_CLAMP)) ? lfp_pkg::MAG_W'(lfp_pkg::MAG_CLAMP)
                                                   : mag_full[lfp_pkg::MAG_W-1:0];
    end
  end

  // divide by 100 through the reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      prodq <= lfp_pkg::PRODQ_W'(mag6) * lfp_pkg::PRODQ_W'(lfp_pkg::DIV_RECIP);
      q_neg <= neg6;
    end
  end

  assign q_mag = prodq[lfp_pkg::DIV_SHIFT +: lfp_pkg::Q_W];

endmodule

FILE: rtl/lfp_drive.sv
module lfp_drive (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  lfp_pkg::tag_t                       tag7,
  input  logic [1:0]                          event7,
  input  logic [lfp_pkg::Q_W-1:0]             q_mag,
  input  logic                                q_neg,
  output logic                                out_valid,
  output logic [lfp_pkg::OUT_TDATA_W-1:0]     out_data
);

  logic [1:0]                      left_status, right_status;
  logic [lfp_pkg::DUTY_W-1:0]      left_duty, right_duty;
  logic                            steer_left, steer_right, heartbeat;
  logic [lfp_pkg::TURN_W-1:0]      last_turn;
  logic                            loaded;

  logic [1:0]                      left_status_next, right_status_next;
  logic [lfp_pkg::DUTY_W-1:0]      left_duty_next, right_duty_next;
  logic                            steer_left_next, steer_right_next, heartbeat_next;
  logic [lfp_pkg::TURN_W-1:0]      last_turn_next;
  logic                            loaded_next;

  logic                            back;
  logic [lfp_pkg::Q_W-1:0]         over;
  logic [1:0]                      cmd_status;
  logic [lfp_pkg::DUTY_W-1:0]      cmd_duty;
  logic [lfp_pkg::TURN_W-1:0]      turn;
  logic                            lf, lb, rf, rb;
  logic                            is_end;

  assign is_end = tag7.valid && tag7.is_end;

  // wheel command for the turn magnitude
  always_comb begin
    back = q_mag > lfp_pkg::Q_W'(lfp_pkg::DUTY_FULL);
    over = q_mag - lfp_pkg::Q_W'(lfp_pkg::DUTY_FULL);
    if (back) begin
      cmd_status = lfp_pkg::STATUS_BWD;
      cmd_duty   = (over > lfp_pkg::Q_W'(lfp_pkg::DUTY_FULL)) ? lfp_pkg::DUTY_FULL
                                                              : over[lfp_pkg::DUTY_W-1:0];
    end else begin
      cmd_status = lfp_pkg::STATUS_FWD;
      cmd_duty   = lfp_pkg::DUTY_W'(lfp_pkg::Q_W'(lfp_pkg::DUTY_FULL) - q_mag);
    end
    if (q_neg) begin
      turn = lfp_pkg::TURN_W'(-q_mag);
    end else begin
      turn = (q_mag > lfp_pkg::TURN_POS_MAX) ? lfp_pkg::TURN_POS_MAX : q_mag;
    end
  end

  // state after this tick
  always_comb begin
    left_status_next  = left_status;
    right_status_next = right_status;
    left_duty_next    = left_duty;
    right_duty_next   = right_duty;
    steer_left_next   = steer_left;
    steer_right_next  = steer_right;
    heartbeat_next    = heartbeat;
    last_turn_next    = last_turn;
    loaded_next       = loaded;
    if (is_end) begin
      heartbeat_next = !heartbeat;
      last_turn_next = turn;
      loaded_next    = 1'b1;
      if (q_mag != '0) begin
        if (!q_neg) begin
          steer_left_next   = 1'b1;
          steer_right_next  = 1'b0;
          right_status_next = lfp_pkg::STATUS_FWD;
          right_duty_next   = lfp_pkg::DUTY_FULL;
          left_status_next  = cmd_status;
          left_duty_next    = cmd_duty;
        end else begin
          steer_left_next   = 1'b0;
          steer_right_next  = 1'b1;
          left_status_next  = lfp_pkg::STATUS_FWD;
          left_duty_next    = lfp_pkg::DUTY_FULL;
          right_status_next = cmd_status;
          right_duty_next   = cmd_duty;
        end
      end
    end
  end

  // pin levels: on from the reload until the count passes the duty
  always_comb begin
    lf = loaded_next && (left_status_next == lfp_pkg::STATUS_FWD) &&
         (tag7.count <= left_duty_next);
    lb = loaded_next && (left_status_next == lfp_pkg::STATUS_BWD) &&
         (tag7.count <= left_duty_next);
    rf = loaded_next && (right_status_next == lfp_pkg::STATUS_FWD) &&
         (tag7.count <= right_duty_next);
    rb = loaded_next && (right_status_next == lfp_pkg::STATUS_BWD) &&
         (tag7.count <= right_duty_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_status  <= lfp_pkg::STATUS_FWD;
      right_status <= lfp_pkg::STATUS_FWD;
      left_duty    <= lfp_pkg::DUTY_RESET;
      right_duty   <= lfp_pkg::DUTY_RESET;
      steer_left   <= 1'b0;
      steer_right  <= 1'b0;
      heartbeat    <= 1'b0;
      last_turn    <= '0;
      loaded       <= 1'b0;
      out_valid    <= 1'b0;
    end else if (en) begin
      left_status  <= left_status_next;
      right_status <= right_status_next;
      left_duty    <= left_duty_next;
      right_duty   <= right_duty_next;
      steer_left   <= steer_left_next;
      steer_right  <= steer_right_next;
      heartbeat    <= heartbeat_next;
      last_turn    <= last_turn_next;
      loaded       <= loaded_next;
      out_valid    <= tag7.valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= {6'b0, last_turn_next, (is_end ? event7 : lfp_pkg::EV_NONE), is_end,
                   heartbeat_next, steer_right_next, steer_left_next, rb, rf, lb, lf};
    end
  end

endmodule

FILE: rtl/line_follow_pid_motor_pwm.sv
// throughput: one tick per cycle, set by the pipeline that advances as a whole
// whenever the result register is empty or being taken
// reset (rst, synchronous): gains and thresholds return to defaults, pwm counter to 0,
// both wheels forward at duty 90, drive pins and lamps off, controller memory cleared
module line_follow_pid_motor_pwm (
  input  logic                                clk,
  input  logic                                rst,
  // sensor_left [7:0], sensor_right [15:8]
  input  logic [lfp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // left_forward [0], left_backward [1], right_forward [2], right_backward [3],
  // steer_left_lamp [4], steer_right_lamp [5], heartbeat [6], period_end [7],
  // junction_event [9:8], turn_value [25:10], zero [31:26]
  output logic [lfp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we,
  input  logic [lfp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lfp_pkg::GAIN_W-1:0]          cfg_data
);

  lfp_pkg::cfg_t                           cfg;
  lfp_pkg::tag_t                           tag_pipe [1:7];
  logic [lfp_pkg::CNT_W-1:0]               pwm_count;
  logic [lfp_pkg::BYTE_W-1:0]              left1, right1;
  logic                                    en;
  logic                                    accept;
  logic                                    tick_end;

  logic signed [lfp_pkg::ERR_W-1:0]         err3;
  logic signed [lfp_pkg::INTEGRAL_BITS-1:0] esum3;
  logic signed [lfp_pkg::DERR_W-1:0]        derr3;
  logic [1:0]                               event3, event4, event5, event6, event7;
  logic [lfp_pkg::Q_W-1:0]                  q_mag;
  logic                                     q_neg;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;
  assign tick_end      = (pwm_count == lfp_pkg::CNT_W'(lfp_pkg::PWM_TOP));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p           <= 10'd70;
      cfg.gain_i           <= 10'd1;
      cfg.gain_d           <= 10'd700;
      cfg.dark_threshold   <= 8'd199;
      cfg.junction_periods <= 8'd10;
      cfg.right_offset     <= 8'd25;
    end else if (cfg_we) begin
      case (cfg_index)
        lfp_pkg::REG_GAIN_P:    cfg.gain_p           <= cfg_data;
        lfp_pkg::REG_GAIN_I:    cfg.gain_i           <= cfg_data;
        lfp_pkg::REG_GAIN_D:    cfg.gain_d           <= cfg_data;
        lfp_pkg::REG_DARK_TH:   cfg.dark_threshold   <= cfg_data[lfp_pkg::BYTE_W-1:0];
        lfp_pkg::REG_JUNC_PER:  cfg.junction_periods <= cfg_data[lfp_pkg::BYTE_W-1:0];
        lfp_pkg::REG_RIGHT_OFS: cfg.right_offset     <= cfg_data[lfp_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // pwm counter, advanced by each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_count <= '0;
    end else if (accept) begin
      pwm_count <= tick_end ? '0 : pwm_count + 1'b1;
    end
  end

  // input register and tag pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 7; k++) begin
        tag_pipe[k].valid <= 1'b0;
      end
    end else if (en) begin
      tag_pipe[1].valid <= s_axis_tvalid;
      for (int k = 2; k <= 7; k++) begin
        tag_pipe[k].valid <= tag_pipe[k-1].valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_pipe[1].is_end <= tick_end;
      tag_pipe[1].count  <= tick_end ? '0 : pwm_count + 1'b1;
      left1              <= s_axis_tdata[lfp_pkg::BYTE_W-1:0];
      right1             <= s_axis_tdata[lfp_pkg::IN_TDATA_W-1:lfp_pkg::BYTE_W];
      for (int k = 2; k <= 7; k++) begin
        tag_pipe[k].is_end <= tag_pipe[k-1].is_end;
        tag_pipe[k].count  <= tag_pipe[k-1].count;
      end
      event4 <= event3;
      event5 <= event4;
      event6 <= event5;
      event7 <= event6;
    end
  end

  lfp_error u_error (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .cfg    (cfg),
    .tag1   (tag_pipe[1]),
    .tag2   (tag_pipe[2]),
    .left1  (left1),
    .right1 (right1),
    .err3   (err3),
    .esum3  (esum3),
    .derr3  (derr3),
    .event3 (event3)
  );

  lfp_pid u_pid (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .err3  (err3),
    .esum3 (esum3),
    .derr3 (derr3),
    .q_mag (q_mag),
    .q_neg (q_neg)
  );

  lfp_drive u_drive (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .tag7      (tag_pipe[7]),
    .event7    (event7),
    .q_mag     (q_mag),
    .q_neg     (q_neg),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import lfp_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RAND_TICKS   = 1550;
  localparam int RAND_PERIODS = 40;
  localparam int QUIET_TICKS  = 250;
  localparam int DRAIN_TAIL   = 16;
  localparam int TURN_SCALE   = 100;
  localparam int DUTY_MAX     = int'(DUTY_FULL);
  localparam int TURN_HI      = 32767;
  localparam int TURN_LO      = -32768;
  localparam int DARK_SAT     = 255;
  localparam int JP_NEVER     = 255;

  // indexes past the register list, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // one result transaction, lowest bit last
  typedef struct packed {
    logic [5:0]         pad;
    logic signed [15:0] turn;
    logic [1:0]         junction;
    logic               period_end;
    logic               heartbeat;
    logic               steer_right_lamp;
    logic               steer_left_lamp;
    logic               right_backward;
    logic               right_forward;
    logic               left_backward;
    logic               left_forward;
  } drive_word_t;

  typedef enum logic [0:0] {ROW_RUN, ROW_CFG} row_kind_e;

  // directed row: a run of ticks with fixed sensor bytes, or one register write
  typedef struct packed {
    row_kind_e   kind;
    logic [9:0]  a;
    logic [9:0]  b;
    logic [7:0]  n;
    logic        chk;
    logic [31:0] word;
  } plan_row_t;

  typedef enum int {SC_DARK, SC_LINE, SC_WIDE, SC_EDGE, SC_HARD_LEFT, SC_HARD_RIGHT} scene_e;
  typedef enum int {
    CM_DEFAULT, CM_RANDOM, CM_ZERO, CM_MAX, CM_DIRECT, CM_WINDUP, CM_JUNCTION
  } cfg_mode_e;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;  // sensor_left [7:0], sensor_right [15:8]
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // left_forward [0], left_backward [1], right_forward [2], right_backward [3],
  // steer_left_lamp [4], steer_right_lamp [5], heartbeat [6], period_end [7],
  // junction_event [9:8], turn_value [25:10], zero [31:26]
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [GAIN_W-1:0]       cfg_data = '0;

  line_follow_pid_motor_pwm DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // steering model state
  int          cfg_gp, cfg_gi, cfg_gd, cfg_thr, cfg_jp, cfg_ofs;
  int          pwm_cnt, l_duty, r_duty, prev_err, dark_cnt, junc_seen, turn_q;
  logic [1:0]  l_dir, r_dir;
  longint      err_sum;
  logic [3:0]  pins;
  logic [2:0]  lamps;

  drive_word_t pending_words[$];
  plan_row_t   plan[0:31];
  int          plan_len = 0;

  int  mismatches = 0;
  int  cycles = 0;
  int  n_ticks = 0, n_periods = 0, n_junctions = 0, n_settings = 0;
  int  n_turn_sat = 0, n_backward = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b1;

  function automatic logic [1:0] wheel_pins(logic [1:0] dir);
    if (dir == STATUS_FWD) return 2'b01;
    if (dir == STATUS_BWD) return 2'b10;
    return 2'b00;
  endfunction

  // direction and duty of the wheel on the inside of the turn
  function automatic void steer_wheel(longint mag, output logic [1:0] dir, output int duty);
    if (mag > DUTY_MAX) begin
      dir = STATUS_BWD;
      duty = (mag - DUTY_MAX > DUTY_MAX) ? DUTY_MAX : int'(mag - DUTY_MAX);
      n_backward++;
    end else begin
      dir = STATUS_FWD;
      duty = DUTY_MAX - int'(mag);
    end
  endfunction

  // advance the steering model by one pwm tick
  function automatic drive_word_t next_drive_word(logic [7:0] sl, logic [7:0] sr);
    drive_word_t w;
    int          left_v, right_v, err;
    longint      total, sum_hi;
    logic        closed;
    logic [1:0]  ev;
    w = '0;
    closed = 1'b0;
    ev = EV_NONE;
    n_ticks++;
    if (pwm_cnt < PWM_TOP) begin
      pwm_cnt++;
    end else begin
      closed = 1'b1;
      n_periods++;
      left_v = int'(sl);
      right_v = (int'(sr) * 9) / 10 + cfg_ofs;
      err = left_v - right_v;
      // integral saturates at the signed accumulator limits
      sum_hi = (longint'(1) <<< (INTEGRAL_BITS - 1)) - 1;
      err_sum = err_sum + err;
      if (err_sum > sum_hi) err_sum = sum_hi;
      if (err_sum < -sum_hi - 1) err_sum = -sum_hi - 1;
      total = longint'(cfg_gp) * err + longint'(cfg_gi) * err_sum
            + longint'(cfg_gd) * (err - prev_err);
      prev_err = err;
      total = total / TURN_SCALE;
      if (total > TURN_HI) begin
        turn_q = TURN_HI;
        n_turn_sat++;
      end else if (total < TURN_LO) begin
        turn_q = TURN_LO;
        n_turn_sat++;
      end else begin
        turn_q = int'(total);
      end
      // turn picks wheel commands, zero keeps the last ones
      if (total > 0) begin
        lamps = (lamps & 3'b100) | 3'b001;
        r_dir = STATUS_FWD;
        r_duty = DUTY_MAX;
        steer_wheel(total, l_dir, l_duty);
      end else if (total < 0) begin
        lamps = (lamps & 3'b100) | 3'b010;
        l_dir = STATUS_FWD;
        l_duty = DUTY_MAX;
        steer_wheel(-total, r_dir, r_duty);
      end
      // junction check after the pid step
      if (left_v >= cfg_thr && right_v >= cfg_thr) begin
        if (dark_cnt < DARK_SAT) dark_cnt++;
        if (dark_cnt > cfg_jp) begin
          dark_cnt = 0;
          if (junc_seen < int'(JUNCTIONS_MAX)) junc_seen++;
          ev = (junc_seen == 1) ? EV_FIRST : EV_LATER;
          err_sum = 0;
          prev_err = 0;
          n_junctions++;
        end
      end else begin
        dark_cnt = 0;
      end
      lamps ^= 3'b100;
      pwm_cnt = 0;
      pins = {wheel_pins(r_dir), wheel_pins(l_dir)};
    end
    if (pwm_cnt > l_duty) pins[1:0] = 2'b00;
    if (pwm_cnt > r_duty) pins[3:2] = 2'b00;
    w.left_forward     = pins[0];
    w.left_backward    = pins[1];
    w.right_forward    = pins[2];
    w.right_backward   = pins[3];
    w.steer_left_lamp  = lamps[0];
    w.steer_right_lamp = lamps[1];
    w.heartbeat        = lamps[2];
    w.period_end       = closed;
    w.junction         = ev;
    w.turn             = turn_q[15:0];
    return w;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
    case (idx)
      REG_GAIN_P:    cfg_gp  = int'(data);
      REG_GAIN_I:    cfg_gi  = int'(data);
      REG_GAIN_D:    cfg_gd  = int'(data);
      REG_DARK_TH:   cfg_thr = int'(data[7:0]);
      REG_JUNC_PER:  cfg_jp  = int'(data[7:0]);
      REG_RIGHT_OFS: cfg_ofs = int'(data[7:0]);
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_row(row_kind_e kind, int a, int b, int n, bit chk, logic [31:0] word);
    plan[plan_len] = '{kind, a[9:0], b[9:0], n[7:0], chk, word};
    plan_len++;
  endtask

  // one tick transaction, with an optional gap before it
  task automatic send_tick(logic [7:0] sl, logic [7:0] sr, bit typed, logic [31:0] word);
    drive_word_t w;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sr, sl};
    do @(posedge clk); while (!s_axis_tready);
    w = next_drive_word(sl, sr);
    pending_words.push_back(typed ? drive_word_t'(word) : w);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data, bit last);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
    if (last) cfg_we <= 1'b0;
  endtask

  task automatic program_regs(int gp, int gi, int gd, int thr, int jp, int ofs);
    bit spare;
    spare = ($urandom_range(0, 3) == 0);
    drain();
    cfg_write(REG_GAIN_P, gp[9:0], 1'b0);
    cfg_write(REG_GAIN_I, gi[9:0], 1'b0);
    cfg_write(REG_GAIN_D, gd[9:0], 1'b0);
    cfg_write(REG_DARK_TH, thr[9:0], 1'b0);
    cfg_write(REG_JUNC_PER, jp[9:0], 1'b0);
    cfg_write(REG_RIGHT_OFS, ofs[9:0], !spare);
    if (spare)
      cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom_range(0, 1023), 1'b1);
    n_settings++;
  endtask

  task automatic scene_bytes(scene_e sc, output logic [7:0] sl, output logic [7:0] sr);
    int l, r;
    r = $urandom_range(0, 255);
    l = $urandom_range(0, 255);
    case (sc)
      SC_DARK: begin
        l = $urandom_range(cfg_thr, 255);
        r = $urandom_range(200, 255);
      end
      SC_LINE: begin
        l = (r * 9) / 10 + cfg_ofs + int'($urandom_range(0, 20)) - 10;
        if (l < 0) l = 0;
        if (l > 255) l = 255;
      end
      SC_EDGE: begin
        l = $urandom_range(0, 1) * 255;
        r = $urandom_range(0, 1) * 255;
      end
      SC_HARD_LEFT: begin
        l = 255;
        r = 0;
      end
      SC_HARD_RIGHT: begin
        l = 0;
        r = 255;
      end
      default: ;
    endcase
    sl = l[7:0];
    sr = r[7:0];
  endtask

  // random tick, with a chosen scene where the tick closes a period
  task automatic run_tick(cfg_mode_e mode, bit hard_neg, inout int ends);
    scene_e     sc;
    logic [7:0] sl, sr;
    sl = $urandom_range(0, 255);
    sr = $urandom_range(0, 255);
    if (pwm_cnt == PWM_TOP) begin
      if (mode == CM_WINDUP)
        sc = hard_neg ? SC_HARD_RIGHT : SC_HARD_LEFT;
      else if (mode == CM_JUNCTION && $urandom_range(0, 3) != 0)
        sc = SC_DARK;
      else
        sc = scene_e'($urandom_range(SC_DARK, SC_HARD_RIGHT));
      scene_bytes(sc, sl, sr);
      ends++;
    end
    send_tick(sl, sr, 1'b0, '0);
  endtask

  // sink side stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest expected word
  always @(posedge clk) begin : result_check
    drive_word_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_words.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        check_field("left_forward", want.left_forward, got.left_forward);
        check_field("left_backward", want.left_backward, got.left_backward);
        check_field("right_forward", want.right_forward, got.right_forward);
        check_field("right_backward", want.right_backward, got.right_backward);
        check_field("steer_left_lamp", want.steer_left_lamp, got.steer_left_lamp);
        check_field("steer_right_lamp", want.steer_right_lamp, got.steer_right_lamp);
        check_field("heartbeat", want.heartbeat, got.heartbeat);
        check_field("period_end", want.period_end, got.period_end);
        check_field("junction_event", want.junction, got.junction);
        check_field("turn_value", int'(want.turn), int'(got.turn));
        check_field("tdata padding", want.pad, got.pad);
      end
    end
  end

  // run time limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int        rnd_ticks, rnd_ends, n_ends, gp, gi, gd, thr, jp, ofs;
    bit        hard_neg;
    cfg_mode_e mode;

    // model state after reset
    cfg_gp = 70; cfg_gi = 1; cfg_gd = 700;
    cfg_thr = 199; cfg_jp = 10; cfg_ofs = 25;
    pwm_cnt = 0; l_dir = STATUS_FWD; r_dir = STATUS_FWD;
    l_duty = int'(DUTY_RESET); r_duty = int'(DUTY_RESET);
    prev_err = 0; err_sum = 0; dark_cnt = 0; junc_seen = 0;
    pins = '0; lamps = '0; turn_q = 0;

    // directed rows, period ends fall on every hundredth tick
    add_row(ROW_RUN, 0, 0, 1, 1'b1, 32'h0000_0000);      // first tick after reset
    add_row(ROW_RUN, 25, 0, 99, 1'b1, 32'h0000_00C5);    // balanced, turn stays zero
    add_row(ROW_RUN, 255, 0, 100, 1'b0, '0);             // strongest positive error
    add_row(ROW_RUN, 0, 255, 100, 1'b0, '0);             // strongest negative error
    add_row(ROW_RUN, 255, 255, 100, 1'b0, '0);           // both dark at defaults
    // proportional only, so the turn equals the error
    add_row(ROW_CFG, REG_GAIN_P, 100, 0, 1'b0, '0);
    add_row(ROW_CFG, REG_GAIN_I, 0, 0, 1'b0, '0);
    add_row(ROW_CFG, REG_GAIN_D, 0, 0, 1'b0, '0);
    add_row(ROW_CFG, REG_RIGHT_OFS, 0, 0, 1'b0, '0);
    add_row(ROW_RUN, 100, 0, 100, 1'b1, 32'h0001_90D5);  // left duty zero at reload
    add_row(ROW_RUN, 100, 0, 1, 1'b1, 32'h0001_9054);    // and off one tick later
    add_row(ROW_RUN, 101, 0, 99, 1'b0, '0);              // just over into backward
    add_row(ROW_RUN, 200, 0, 100, 1'b0, '0);
    add_row(ROW_RUN, 255, 0, 100, 1'b0, '0);             // backward duty capped
    add_row(ROW_RUN, 0, 112, 100, 1'b0, '0);             // right duty zero
    add_row(ROW_RUN, 0, 113, 100, 1'b0, '0);
    add_row(ROW_RUN, 0, 255, 100, 1'b0, '0);
    // everything dark, junction on every period
    add_row(ROW_CFG, REG_JUNC_PER, 0, 0, 1'b0, '0);
    add_row(ROW_CFG, REG_DARK_TH, 0, 0, 1'b0, '0);
    add_row(ROW_RUN, 0, 0, 100, 1'b0, '0);               // first junction
    add_row(ROW_RUN, 7, 9, 100, 1'b0, '0);               // later junction
    // dropped index, truncated data, junctions disabled
    add_row(ROW_CFG, REG_SPARE_A, 1023, 0, 1'b0, '0);
    add_row(ROW_CFG, REG_DARK_TH, 1023, 0, 1'b0, '0);
    add_row(ROW_CFG, REG_JUNC_PER, JP_NEVER, 0, 1'b0, '0);
    add_row(ROW_RUN, 255, 255, 100, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < plan_len; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind != ROW_CFG) drain();
        cfg_write(plan[i].a[CFG_IDX_W-1:0], plan[i].b,
                  i == plan_len - 1 || plan[i+1].kind != ROW_CFG);
      end else begin
        for (int k = 0; k < int'(plan[i].n); k++)
          send_tick(plan[i].a[7:0], plan[i].b[7:0], plan[i].chk && k == plan[i].n - 1,
                    plan[i].word);
      end
    end

    // random phases, each under its own register setting
    rnd_ticks = 0;
    rnd_ends = 0;
    while (rnd_ticks < RAND_TICKS || rnd_ends < RAND_PERIODS) begin
      mode = cfg_mode_e'($urandom_range(CM_DEFAULT, CM_JUNCTION));
      hard_neg = $urandom_range(0, 1);
      gp = $urandom_range(0, 1023); gi = $urandom_range(0, 1023);
      gd = $urandom_range(0, 1023); thr = $urandom_range(0, 1023);
      jp = $urandom_range(0, 1023); ofs = $urandom_range(0, 1023);
      case (mode)
        CM_DEFAULT: begin
          gp = 70; gi = 1; gd = 700; thr = 199; jp = 10; ofs = 25;
        end
        CM_ZERO: begin
          gp = 0; gi = 0; gd = 0; thr = 0; jp = 0; ofs = 0;
        end
        CM_MAX: begin
          gp = 1023; gi = 1023; gd = 1023; thr = 1023; jp = 1023; ofs = 1023;
        end
        CM_DIRECT: begin
          gp = 100; gi = 0; gd = 0; thr = $urandom_range(0, 255);
          jp = $urandom_range(0, 3); ofs = $urandom_range(0, 255);
        end
        CM_WINDUP: begin
          gp = $urandom_range(0, 200); gi = 1023; gd = $urandom_range(0, 100);
          thr = 255; jp = JP_NEVER; ofs = hard_neg ? 255 : 0;
        end
        CM_JUNCTION: begin
          gp = $urandom_range(0, 150); gi = $urandom_range(0, 20);
          gd = $urandom_range(0, 300); thr = $urandom_range(0, 180);
          jp = $urandom_range(0, 4);
        end
        default: ;
      endcase
      program_regs(gp, gi, gd, thr, jp, ofs);
      idle_on = ($urandom_range(0, 3) != 0);
      n_ends = (mode == CM_WINDUP) ? 14 : $urandom_range(1, 6);
      while (n_ends > 0) begin
        int ended;
        ended = 0;
        run_tick(mode, hard_neg, ended);
        n_ends -= ended;
        rnd_ends += ended;
        rnd_ticks++;
      end
      // stop mid period now and then before the next setting
      repeat ($urandom_range(0, 60)) begin
        int ended;
        ended = 0;
        run_tick(mode, hard_neg, ended);
        rnd_ticks++;
      end
    end

    // closing stretch at full rate on both sides
    idle_on = 1'b0;
    repeat (QUIET_TICKS) begin
      int ended;
      ended = 0;
      run_tick(CM_RANDOM, 1'b0, ended);
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d expected result transactions never arrived", pending_words.size());
      mismatches++;
    end

    $display("covered %0d ticks over %0d pwm periods with %0d junction events",
             n_ticks, n_periods, n_junctions);
    $display("under %0d register settings, %0d clipped turns, %0d backward wheel commands",
             n_settings, n_turn_sat, n_backward);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: line_follow_pid_motor_pwm.f
rtl/lfp_pkg.sv
rtl/lfp_error.sv
rtl/lfp_pid.sv
rtl/lfp_drive.sv
rtl/line_follow_pid_motor_pwm.sv
sim/tb_top.sv
